// File: hdl/sttab_pkg.sv
// ----------------------------------------------------------------------------
// sttab_pkg
// Request kinds, status codes and shared types of the software timer table.
// ----------------------------------------------------------------------------
package sttab_pkg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_ALLOC  = 3'd1;
    localparam logic [2:0] KIND_ARM    = 3'd2;
    localparam logic [2:0] KIND_DISARM = 3'd3;
    localparam logic [2:0] KIND_QUERY  = 3'd4;
    localparam logic [2:0] KIND_SCAN   = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_FREE = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [1:0] STAT_NOT_ACT = 2'd3;

    localparam int          MAX_RESULTS    = 16;
    localparam int          HIT_W          = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] NOT_ACTIVE_REM = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        due;
        logic [31:0] rem;
    } age_t;

endpackage

// File: hdl/sttab_age.sv
// ----------------------------------------------------------------------------
// sttab_age
// Registered elapsed-time stage and due compare for one timer entry.
// ----------------------------------------------------------------------------
module sttab_age #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  clk,
    input  logic [COUNT_BITS-1:0] tick,
    input  logic [COUNT_BITS-1:0] start_tick,
    input  logic [31:0]           delay,
    output sttab_pkg::age_t       age
);
    import sttab_pkg::*;

    logic [COUNT_BITS-1:0] elapsed_reg;
    logic [31:0]           delay_reg;

    always_ff @(posedge clk)
    begin
        elapsed_reg <= tick - start_tick;
        delay_reg   <= delay;
    end

    always_comb
    begin
        age.due = 32'(elapsed_reg) >= delay_reg;
        age.rem = delay_reg - 32'(elapsed_reg);
    end

endmodule

// File: hdl/software_timer_table.sv
// ----------------------------------------------------------------------------
// software_timer_table
// Table of software timers sharing one tick counter, kept in a synchronous RAM.
// ----------------------------------------------------------------------------
// A request transfers when start is high and busy is low. Its results appear
// on the result ports one cycle at a time, each marked by result_valid, and
// last marks the final result of a request. The receiver cannot stall.
// Tick and unused kinds: result in the next cycle, busy stays low.
// Arm and disarm: one RAM read, then write back.
// Query: RAM read, elapsed-time register, then compare.
// Allocate: one claim bit checked per cycle.
// Scan: the RAM port is read once per entry and the entries flow through a
// two-stage pipe (RAM read, elapsed-time register) ahead of the compare. An
// expired entry is held one step so that the final one can carry last; an
// empty scan gives one result with expired_hit low.
// Reset clears the tick counter, the running flag, the active count and the
// claim bits; entry words of unclaimed entries are ignored.
// ----------------------------------------------------------------------------
module software_timer_table #(
    parameter int NUM_TIMERS = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  entry_index,
    input  logic [31:0] delay_ticks,
    output logic        result_valid,
    output logic [1:0]  result_status,
    output logic [3:0]  result_entry,
    output logic [31:0] remaining_ticks,
    output logic        expired_hit,
    output logic        timer_running,
    output logic        last
);
    import sttab_pkg::*;

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
    localparam int WORD_W = COUNT_BITS + 33;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [7:0]       NUM_IDX  = 8'(NUM_TIMERS);
    localparam logic [31:0]      CNT_MASK = 32'((33'd1 << COUNT_BITS) - 33'd1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ALLOC  = 3'd1;
    localparam logic [2:0] S_ARMDIS = 3'd2;
    localparam logic [2:0] S_QRY1   = 3'd3;
    localparam logic [2:0] S_QRY2   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_SWAIT  = 3'd6;
    localparam logic [2:0] S_SFIN   = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            kind_reg, kind_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [31:0]           delay_reg, delay_next;
    logic [COUNT_BITS-1:0] tick_reg, tick_next;
    logic                  running_reg, running_next;
    logic [CNT_W-1:0]      act_cnt_reg, act_cnt_next;
    logic [NUM_TIMERS-1:0] claimed_reg, claimed_next;
    logic [IDX_W-1:0]      ap_reg, ap_next;
    logic [IDX_W-1:0]      sa_reg, sa_next;
    logic [HIT_W-1:0]      hit_cnt_reg, hit_cnt_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;

    logic                  out_vld_reg, out_vld_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [3:0]            out_entry_reg, out_entry_next;
    logic [31:0]           out_rem_reg, out_rem_next;
    logic                  out_hit_reg, out_hit_next;
    logic                  out_run_reg, out_run_next;
    logic                  out_last_reg, out_last_next;

    logic [WORD_W-1:0]     mem [NUM_TIMERS];
    logic [WORD_W-1:0]     rd_word_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_vld_reg, rd_end_reg;
    logic                  ag_act_reg, ag_vld_reg, ag_end_reg;
    logic [IDX_W-1:0]      ag_idx_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;

    logic                  emit;
    logic [1:0]            e_status;
    logic [3:0]            e_entry;
    logic [31:0]           e_rem;
    logic                  e_hit, e_run, e_last;
    logic                  in_range, old_act, hit;
    age_t                  age;

    sttab_age #(
        .COUNT_BITS (COUNT_BITS)
    ) u_age (
        .clk        (clk),
        .tick       (tick_reg),
        .start_tick (rd_word_reg[32 +: COUNT_BITS]),
        .delay      (rd_word_reg[31:0]),
        .age        (age)
    );

    assign busy     = (state_reg != S_IDLE);
    assign in_range = (entry_index < NUM_IDX);
    assign old_act  = rd_word_reg[WORD_W-1] & claimed_reg[rd_idx_reg];
    assign hit      = ag_vld_reg && ag_act_reg && age.due
                      && (hit_cnt_reg < HIT_W'(MAX_RESULTS));

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        delay_next    = delay_reg;
        tick_next     = tick_reg;
        running_next  = running_reg;
        act_cnt_next  = act_cnt_reg;
        claimed_next  = claimed_reg;
        ap_next       = ap_reg;
        sa_next       = sa_reg;
        hit_cnt_next  = hit_cnt_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        rd_addr       = sa_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = {1'b1, tick_reg, delay_reg};
        emit          = 1'b0;
        e_status      = STAT_OK;
        e_entry       = 4'(idx_reg);
        e_rem         = 32'd0;
        e_hit         = 1'b0;
        e_run         = running_reg;
        e_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = IDX_W'(entry_index);
                if (start)
                begin
                    kind_next     = kind;
                    idx_next      = IDX_W'(entry_index);
                    delay_next    = delay_ticks;
                    ap_next       = '0;
                    sa_next       = '0;
                    hit_cnt_next  = '0;
                    pend_vld_next = 1'b0;
                    e_entry       = entry_index[3:0];
                    case (kind)
                        KIND_TICK:
                        begin
                            if (running_reg)
                                tick_next = tick_reg + 1'b1;
                            emit = 1'b1;
                        end
                        KIND_ALLOC:
                            state_next = S_ALLOC;
                        KIND_ARM, KIND_DISARM:
                        begin
                            if (in_range)
                                state_next = S_ARMDIS;
                            else
                            begin
                                emit     = 1'b1;
                                e_status = STAT_RANGE;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (in_range)
                                state_next = S_QRY1;
                            else
                            begin
                                emit     = 1'b1;
                                e_status = STAT_RANGE;
                            end
                        end
                        KIND_SCAN:
                        begin
                            running_next = running_reg && (act_cnt_reg != '0);
                            state_next   = S_SCAN;
                        end
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (!claimed_reg[ap_reg])
                begin
                    claimed_next[ap_reg] = 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = ap_reg;
                    wr_data    = {1'b0, tick_reg, delay_reg};
                    emit       = 1'b1;
                    e_entry    = 4'(ap_reg);
                    state_next = S_IDLE;
                end
                else if (ap_reg == LAST_IDX)
                begin
                    emit       = 1'b1;
                    e_status   = STAT_NO_FREE;
                    e_entry    = 4'd0;
                    state_next = S_IDLE;
                end
                else
                    ap_next = ap_reg + 1'b1;
            end
            S_ARMDIS:
            begin
                wr_en                 = 1'b1;
                claimed_next[idx_reg] = 1'b1;
                emit                  = 1'b1;
                state_next            = S_IDLE;
                if (kind_reg == KIND_ARM)
                begin
                    running_next = 1'b1;
                    e_run        = 1'b1;
                    if (!old_act)
                        act_cnt_next = act_cnt_reg + 1'b1;
                end
                else
                begin
                    wr_data = {1'b0, tick_reg, delay_reg};
                    if (old_act)
                        act_cnt_next = act_cnt_reg - 1'b1;
                end
            end
            S_QRY1:
                state_next = S_QRY2;
            S_QRY2:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                if (!ag_act_reg)
                begin
                    e_status = STAT_NOT_ACT;
                    e_rem    = NOT_ACTIVE_REM;
                end
                else
                    e_rem = age.due ? CNT_MASK : age.rem;
            end
            S_SCAN, S_SWAIT:
            begin
                if (state_reg == S_SCAN)
                begin
                    if (sa_reg == LAST_IDX)
                        state_next = S_SWAIT;
                    else
                        sa_next = sa_reg + 1'b1;
                end
                if (hit)
                begin
                    hit_cnt_next  = hit_cnt_reg + 1'b1;
                    pend_vld_next = 1'b1;
                    pend_idx_next = ag_idx_reg;
                    if (pend_vld_reg)
                    begin
                        emit    = 1'b1;
                        e_entry = 4'(pend_idx_reg);
                        e_hit   = 1'b1;
                        e_last  = 1'b0;
                    end
                end
                if (ag_vld_reg && ag_end_reg)
                    state_next = S_SFIN;
            end
            S_SFIN:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                e_entry    = pend_vld_reg ? 4'(pend_idx_reg) : 4'd0;
                e_hit      = pend_vld_reg;
            end
            default:
                state_next = S_IDLE;
        endcase

        out_vld_next    = emit;
        out_status_next = emit ? e_status : out_status_reg;
        out_entry_next  = emit ? e_entry : out_entry_reg;
        out_rem_next    = emit ? e_rem : out_rem_reg;
        out_hit_next    = emit ? e_hit : out_hit_reg;
        out_run_next    = emit ? e_run : out_run_reg;
        out_last_next   = emit ? e_last : out_last_reg;
    end

    // entry RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_word_reg <= mem[rd_addr];
        rd_idx_reg  <= rd_addr;
        ag_idx_reg  <= rd_idx_reg;
        ag_act_reg  <= old_act;
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        delay_reg       <= delay_next;
        ap_reg          <= ap_next;
        sa_reg          <= sa_next;
        pend_idx_reg    <= pend_idx_next;
        out_status_reg  <= out_status_next;
        out_entry_reg   <= out_entry_next;
        out_rem_reg     <= out_rem_next;
        out_hit_reg     <= out_hit_next;
        out_run_reg     <= out_run_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            tick_reg     <= '0;
            running_reg  <= 1'b0;
            act_cnt_reg  <= '0;
            claimed_reg  <= '0;
            hit_cnt_reg  <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_end_reg   <= 1'b0;
            ag_vld_reg   <= 1'b0;
            ag_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            running_reg  <= running_next;
            act_cnt_reg  <= act_cnt_next;
            claimed_reg  <= claimed_next;
            hit_cnt_reg  <= hit_cnt_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            rd_vld_reg   <= (state_reg == S_SCAN);
            rd_end_reg   <= (state_reg == S_SCAN) && (sa_reg == LAST_IDX);
            ag_vld_reg   <= rd_vld_reg;
            ag_end_reg   <= rd_end_reg;
        end
    end

    assign result_valid    = out_vld_reg;
    assign result_status   = out_status_reg;
    assign result_entry    = out_entry_reg;
    assign remaining_ticks = out_rem_reg;
    assign expired_hit     = out_hit_reg;
    assign timer_running   = out_run_reg;
    assign last            = out_last_reg;

endmodule

// File: hdl/sttab_checker.sv
// ----------------------------------------------------------------------------
// sttab_checker
// Port-level checks of the software timer table, bound to the top level.
// ----------------------------------------------------------------------------
module sttab_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [1:0]  result_status,
    input logic [31:0] remaining_ticks,
    input logic        expired_hit,
    input logic        last
);
    import sttab_pkg::*;

    // every request transfer is answered at once or holds the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (result_valid || busy))
        else $error("request transfer neither answered nor busy");

    // only scan hits come in groups; a non-final result keeps the block busy
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> (busy && expired_hit))
        else $error("non-final result outside a scan");

    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && expired_hit) |-> (result_status == STAT_OK
            && remaining_ticks == 32'd0))
        else $error("expired result with bad fields");

    a_not_active: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_status == STAT_NOT_ACT)
            |-> (remaining_ticks == NOT_ACTIVE_REM && !expired_hit))
        else $error("not-active result with bad remaining ticks");

endmodule

bind software_timer_table sttab_checker u_sttab_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .result_valid    (result_valid),
    .result_status   (result_status),
    .remaining_ticks (remaining_ticks),
    .expired_hit     (expired_hit),
    .last            (last)
);
